// File: design/istw_pkg.sv
// Shared types, sizes and helpers for the idle-session timing wheel.
// No dependencies; imported by istw_occ and idle_session_timing_wheel.
`default_nettype none

package istw_pkg;

  // Table sizes
  localparam int SESSIONS  = 1024;
  localparam int MAX_SLOTS = 256;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int ID_W     = 32;
  localparam int TIME_W   = 64;
  localparam int PERIOD_W = 32;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IX_W = 8;
  localparam int CFG_D_W  = 32;

  // Derived sizes
  localparam int ENT_IW  = $clog2(SESSIONS);
  localparam int SLOT_IW = $clog2(MAX_SLOTS);
  localparam int OCC_W   = $clog2(SESSIONS + 1);
  localparam int CLR_N   = (SESSIONS > MAX_SLOTS) ? SESSIONS : MAX_SLOTS;
  localparam int CLR_W   = $clog2(CLR_N);

  // Register reset values
  localparam logic [SLOT_W-1:0]   SLOT_TOP_RST = SLOT_W'(60);
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(1000000);
  localparam logic [SLOT_W-1:0]   SLOT_MAX     = SLOT_W'(MAX_SLOTS - 1);

  // Register indexes on the configuration port
  localparam logic [CFG_IX_W-1:0] CFG_SLOT_TOP    = CFG_IX_W'(0);
  localparam logic [CFG_IX_W-1:0] CFG_TICK_PERIOD = CFG_IX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_NOACT  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_EXEC,
    ST_UPD_WAIT,
    ST_UPD_INC,
    ST_TICK,
    ST_TICK_CHK,
    ST_RESULT
  } state_e;

  typedef enum logic [2:0] {
    OCC_NONE,
    OCC_READ,
    OCC_INC,
    OCC_DEC,
    OCC_CLEAR
  } occ_op_e;

  typedef logic [SLOT_IW-1:0] slot_idx_t;
  typedef logic [OCC_W-1:0]   occ_cnt_t;

  typedef struct packed {
    occ_op_e   op;
    slot_idx_t idx;
  } occ_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   session;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  // Clamp a slot value onto a physical slot of the wheel
  function automatic slot_idx_t slot_ix(input logic [SLOT_W-1:0] s);
    slot_idx_t r;
    if (s > SLOT_MAX) begin
      r = SLOT_IW'(MAX_SLOTS - 1);
    end else begin
      r = s[SLOT_IW-1:0];
    end
    return r;
  endfunction

  // Highest usable slot for a programmed top
  function automatic logic [SLOT_W-1:0] eff_top(input logic [SLOT_W-1:0] top);
    logic [SLOT_W-1:0] r;
    if (top > SLOT_MAX) begin
      r = SLOT_MAX;
    end else begin
      r = top;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/idle_session_timing_wheel.sv
// Idle-session timing wheel: session table, scan sequencer, wheel state.
// Depends on istw_pkg and istw_occ.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   in       | in_valid_i / in_stall_o    | kind_i, session_id_i, now_us_i
//   out      | out_valid_o / out_stall_i  | status_o, expire_valid_o,
//            |                            | expire_slot_o
//   cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Insert, update and remove scan the whole session table, one entry per cycle
// through the table's single read port. After reset a clearing pass of
// max(SESSIONS, MAX_SLOTS) indexes (1024) runs over the table and the
// occupancy counters; no word is accepted meanwhile.
// One item is in work at a time; a finished result waits in the output
// register, so the next word is accepted while the result is stalled.
`default_nettype none

module idle_session_timing_wheel (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [istw_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [istw_pkg::ID_W-1:0]        session_id_i,
  input  wire logic [istw_pkg::TIME_W-1:0]      now_us_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [istw_pkg::STATUS_W-1:0]         status_o,
  output logic                                  expire_valid_o,
  output logic [istw_pkg::SLOT_W-1:0]           expire_slot_o,
  // configuration channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [istw_pkg::CFG_IX_W-1:0]    cfg_index_i,
  input  wire logic [istw_pkg::CFG_D_W-1:0]     cfg_data_i
);
  import istw_pkg::*;

  state_e state_q, state_d;

  // Configuration registers
  logic [SLOT_W-1:0]   slot_top_q;
  logic [PERIOD_W-1:0] period_q;

  // Wheel state
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [SLOT_W-1:0] fresh_q, fresh_d;
  logic [TIME_W-1:0] last_q, last_d;

  // Item under work
  kind_e             kind_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] now_q;

  // Clear sweep and scan
  logic [CLR_W-1:0]  clr_q, clr_d;
  logic [ENT_IW-1:0] scan_q, scan_d;
  logic              chk_q, chk_d;
  logic [ENT_IW-1:0] chk_idx_q, chk_idx_d;
  logic              match_q, match_d;
  logic [ENT_IW-1:0] match_idx_q, match_idx_d;
  logic [SLOT_W-1:0] match_slot_q, match_slot_d;
  logic              free_q, free_d;
  logic [ENT_IW-1:0] free_idx_q, free_idx_d;

  // Result being built and output register
  status_e           res_status_q, res_status_d;
  logic              res_ev_q, res_ev_d;
  logic [SLOT_W-1:0] res_es_q, res_es_d;
  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_ev_q;
  logic [SLOT_W-1:0] out_es_q;
  logic              out_load;

  // Session table
  entry_t            ent_mem [SESSIONS];
  entry_t            ent_rd_q;
  logic              ent_we;
  logic [ENT_IW-1:0] ent_waddr;
  entry_t            ent_wdata;

  // Occupancy unit
  occ_cmd_t occ_cmd;
  occ_cnt_t occ_rdata;

  logic              in_accept;
  logic [TIME_W-1:0] elapsed;
  logic [SLOT_W:0]   cur_inc;
  logic [SLOT_W-1:0] cur_next;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Wheel arithmetic: elapsed time and wrapped next slot
  assign elapsed  = now_q - last_q;
  assign cur_inc  = {1'b0, cur_q} + (SLOT_W + 1)'(1);
  assign cur_next = (cur_inc > {1'b0, eff_top(slot_top_q)}) ? '0 : cur_inc[SLOT_W-1:0];

  istw_occ u_occ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (occ_cmd),
    .rdata_o (occ_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_top_q <= SLOT_TOP_RST;
      period_q   <= PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_SLOT_TOP) begin
        slot_top_q <= cfg_data_i[SLOT_W-1:0];
      end else if (cfg_index_i == CFG_TICK_PERIOD) begin
        period_q <= cfg_data_i[PERIOD_W-1:0];
      end
    end
  end

  // Sequencer: next state, table and occupancy commands
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    fresh_d      = fresh_q;
    last_d       = last_q;
    clr_d        = clr_q;
    scan_d       = scan_q;
    chk_d        = 1'b0;
    chk_idx_d    = scan_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_slot_d = match_slot_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    res_ev_d     = res_ev_q;
    res_es_d     = res_es_q;
    ent_we       = 1'b0;
    ent_waddr    = match_idx_q;
    ent_wdata    = '{valid: 1'b1, session: id_q, slot: match_slot_q};
    occ_cmd      = '{op: OCC_NONE, idx: slot_ix(fresh_q)};
    out_load     = 1'b0;

    // Compare the word read in the previous cycle
    if (chk_q) begin
      if (ent_rd_q.valid && ent_rd_q.session == id_q) begin
        match_d      = 1'b1;
        match_idx_d  = chk_idx_q;
        match_slot_d = ent_rd_q.slot;
      end
      if (!ent_rd_q.valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        if ({{(32-CLR_W){1'b0}}, clr_q} < 32'(SESSIONS)) begin
          ent_we    = 1'b1;
          ent_waddr = clr_q[ENT_IW-1:0];
          ent_wdata = '0;
        end
        if ({{(32-CLR_W){1'b0}}, clr_q} < 32'(MAX_SLOTS)) begin
          occ_cmd = '{op: OCC_CLEAR, idx: clr_q[SLOT_IW-1:0]};
        end
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        res_status_d = STATUS_NOACT;
        res_ev_d     = 1'b0;
        res_es_d     = '0;
        if (in_accept) begin
          if (kind_e'(kind_i) == KIND_TICK) begin
            state_d = ST_TICK;
          end else begin
            scan_d  = '0;
            match_d = 1'b0;
            free_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue one table read per cycle
        chk_d     = 1'b1;
        chk_idx_d = scan_q;
        scan_d    = scan_q + ENT_IW'(1);
        if (scan_q == ENT_IW'(SESSIONS - 1)) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESULT;
        case (kind_q)
          KIND_INSERT: begin
            res_status_d = STATUS_REJECT;
            if (!match_q && free_q) begin
              ent_we       = 1'b1;
              ent_waddr    = free_idx_q;
              ent_wdata    = '{valid: 1'b1, session: id_q,
                               slot: SLOT_W'(slot_ix(fresh_q))};
              occ_cmd      = '{op: OCC_INC, idx: slot_ix(fresh_q)};
              res_status_d = STATUS_DONE;
            end
          end
          KIND_UPDATE: begin
            if (match_q && match_slot_q != fresh_q) begin
              ent_we       = 1'b1;
              ent_wdata    = '{valid: 1'b1, session: id_q,
                               slot: SLOT_W'(slot_ix(cur_q))};
              occ_cmd      = '{op: OCC_DEC, idx: slot_ix(match_slot_q)};
              res_status_d = STATUS_DONE;
              state_d      = ST_UPD_WAIT;
            end
          end
          KIND_REMOVE: begin
            if (match_q) begin
              ent_we       = 1'b1;
              ent_wdata    = '0;
              occ_cmd      = '{op: OCC_DEC, idx: slot_ix(match_slot_q)};
              res_status_d = STATUS_DONE;
            end
          end
          default: begin
            res_status_d = STATUS_NOACT;
          end
        endcase
      end
      ST_UPD_WAIT: begin
        // Let the decrement land before the increment reads
        state_d = ST_UPD_INC;
      end
      ST_UPD_INC: begin
        occ_cmd = '{op: OCC_INC, idx: slot_ix(cur_q)};
        state_d = ST_RESULT;
      end
      ST_TICK: begin
        state_d = ST_RESULT;
        if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_q}) begin
          last_d       = now_q;
          fresh_d      = cur_q;
          cur_d        = cur_next;
          occ_cmd      = '{op: OCC_READ, idx: slot_ix(cur_next)};
          res_status_d = STATUS_DONE;
          state_d      = ST_TICK_CHK;
        end
      end
      ST_TICK_CHK: begin
        if (occ_rdata != '0) begin
          res_ev_d = 1'b1;
          res_es_d = cur_q;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        // Hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cur_q   <= '0;
      fresh_q <= eff_top(SLOT_TOP_RST);
      last_q  <= '0;
      chk_q   <= 1'b0;
      match_q <= 1'b0;
      free_q  <= 1'b0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cur_q   <= cur_d;
      fresh_q <= fresh_d;
      last_q  <= last_d;
      chk_q   <= chk_d;
      match_q <= match_d;
      free_q  <= free_d;
      scan_q  <= scan_d;
    end
  end

  // Payload and scan bookkeeping registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_e'(kind_i);
      id_q   <= session_id_i;
      now_q  <= now_us_i;
    end
    chk_idx_q    <= chk_idx_d;
    match_idx_q  <= match_idx_d;
    match_slot_q <= match_slot_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    res_ev_q     <= res_ev_d;
    res_es_q     <= res_es_d;
  end

  // Session table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_q <= ent_mem[scan_q];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_ev_q     <= res_ev_q;
      out_es_q     <= res_es_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign expire_valid_o = out_ev_q;
  assign expire_slot_o  = out_es_q;

  // An expiry is only reported by a tick that advanced the wheel
  a_expire_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expire_valid_o |-> status_o == STATUS_DONE)
    else $error("expiry reported without an advance");

  // A new result always comes from the hand-over state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == ST_RESULT && $past(state_q) != ST_IDLE)
    else $error("result loaded outside hand-over");

  // Once a word is taken the block stays busy in the next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

endmodule

`default_nettype wire

// File: design/istw_occ.sv
// Slot occupancy counters: one memory with a shared increment/decrement unit.
// Depends on istw_pkg. A read-modify-write reads the counter, then writes it back.
`default_nettype none

module istw_occ (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire istw_pkg::occ_cmd_t cmd_i,
  output istw_pkg::occ_cnt_t     rdata_o
);
  import istw_pkg::*;

  occ_cnt_t  mem [MAX_SLOTS];
  occ_cnt_t  rd_q;
  occ_op_e   wb_op_q;
  slot_idx_t wb_idx_q;

  logic      we;
  slot_idx_t waddr;
  occ_cnt_t  wdata;

  // Track the pending write-back of an increment or decrement
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_op_q <= OCC_NONE;
    end else begin
      if (cmd_i.op == OCC_INC || cmd_i.op == OCC_DEC) begin
        wb_op_q <= cmd_i.op;
      end else begin
        wb_op_q <= OCC_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wb_idx_q <= cmd_i.idx;
  end

  // Select the single write: clear sweep, or write-back of the shared adder
  always_comb begin
    we    = 1'b0;
    waddr = cmd_i.idx;
    wdata = '0;
    case (wb_op_q)
      OCC_INC: begin
        we    = 1'b1;
        waddr = wb_idx_q;
        wdata = rd_q + OCC_W'(1);
      end
      OCC_DEC: begin
        we    = 1'b1;
        waddr = wb_idx_q;
        wdata = rd_q - OCC_W'(1);
      end
      default: begin
        if (cmd_i.op == OCC_CLEAR) begin
          we = 1'b1;
        end
      end
    endcase
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[cmd_i.idx];
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for idle_session_timing_wheel: directed and random
// session traffic, checked word by word against an in-bench model of the wheel.
// Depends on istw_pkg and the idle_session_timing_wheel RTL.

module testbench;
  import istw_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RESET_TOP    = 60;
  localparam int RESET_PERIOD = 1000000;

  typedef struct packed {
    status_e           status;
    logic              expire;
    logic [SLOT_W-1:0] slot;
  } wheel_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [KIND_W-1:0] kind_i;
  logic [ID_W-1:0] session_id_i;
  logic [TIME_W-1:0] now_us_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic expire_valid_o;
  logic [SLOT_W-1:0] expire_slot_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IX_W-1:0] cfg_index_i;
  logic [CFG_D_W-1:0] cfg_data_i;

  // Model of the wheel: session table, slot counts, wheel pointers, registers
  bit                 tbl_used [SESSIONS];
  logic [ID_W-1:0]    tbl_id [SESSIONS];
  logic [SLOT_W-1:0]  tbl_slot [SESSIONS];
  int unsigned        slot_count [MAX_SLOTS];
  logic [SLOT_W-1:0]  cur_slot = '0;
  logic [SLOT_W-1:0]  newest_slot = SLOT_W'(RESET_TOP);
  logic [TIME_W-1:0]  last_advance = '0;
  logic [SLOT_W-1:0]  wheel_top_reg = SLOT_W'(RESET_TOP);
  logic [31:0]        wheel_period = 32'(RESET_PERIOD);
  logic [ID_W-1:0]    live_ids [$];
  wheel_word_t        pending_outcomes [$];

  int  feed_gap_pct = 0;
  int  sink_stall_pct = 0;
  int  words_sent = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  hold_req = 1'b0;

  idle_session_timing_wheel i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .session_id_i   (session_id_i),
    .now_us_i       (now_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .expire_valid_o (expire_valid_o),
    .expire_slot_o  (expire_slot_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  function automatic logic [SLOT_W-1:0] clamp_slot(logic [SLOT_W-1:0] s);
    return (s > SLOT_W'(MAX_SLOTS - 1)) ? SLOT_W'(MAX_SLOTS - 1) : s;
  endfunction

  function automatic int find_session(logic [ID_W-1:0] id);
    for (int i = 0; i < SESSIONS; i++) begin
      if (tbl_used[i] && tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int free_entry();
    for (int i = 0; i < SESSIONS; i++) begin
      if (!tbl_used[i]) return i;
    end
    return -1;
  endfunction

  function automatic void drop_live(logic [ID_W-1:0] id);
    foreach (live_ids[i]) begin
      if (live_ids[i] == id) begin
        live_ids.delete(i);
        return;
      end
    end
  endfunction

  // Apply one word to the model and return the word the block must produce
  function automatic wheel_word_t wheel_step(kind_e k, logic [ID_W-1:0] id,
                                             logic [TIME_W-1:0] t);
    wheel_word_t w;
    int e;
    logic [SLOT_W:0] nxt;
    w = '{status: STATUS_NOACT, expire: 1'b0, slot: '0};
    e = find_session(id);
    case (k)
      KIND_INSERT: begin
        w.status = STATUS_REJECT;
        if (e < 0) begin
          e = free_entry();
          if (e >= 0) begin
            tbl_used[e] = 1'b1;
            tbl_id[e]   = id;
            tbl_slot[e] = clamp_slot(newest_slot);
            slot_count[tbl_slot[e]]++;
            live_ids.push_back(id);
            w.status = STATUS_DONE;
          end
        end
      end
      KIND_UPDATE: begin
        // a session already in the freshest slot stays put
        if (e >= 0 && tbl_slot[e] != newest_slot) begin
          slot_count[clamp_slot(tbl_slot[e])]--;
          tbl_slot[e] = clamp_slot(cur_slot);
          slot_count[tbl_slot[e]]++;
          w.status = STATUS_DONE;
        end
      end
      KIND_REMOVE: begin
        if (e >= 0) begin
          slot_count[clamp_slot(tbl_slot[e])]--;
          tbl_used[e] = 1'b0;
          drop_live(id);
          w.status = STATUS_DONE;
        end
      end
      default: begin
        // elapsed time wraps modulo 2^64
        if (t - last_advance >= TIME_W'(wheel_period)) begin
          last_advance = t;
          newest_slot  = cur_slot;
          nxt = {1'b0, cur_slot} + 1'b1;
          if (nxt > {1'b0, clamp_slot(wheel_top_reg)}) nxt = '0;
          cur_slot = nxt[SLOT_W-1:0];
          w.status = STATUS_DONE;
          if (slot_count[clamp_slot(cur_slot)] != 0) begin
            w.expire = 1'b1;
            w.slot   = cur_slot;
          end
        end
      end
    endcase
    return w;
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic logic [ID_W-1:0] known_id();
    if (live_ids.size() == 0 || $urandom_range(9) == 0) return $urandom;
    return live_ids[$urandom_range(live_ids.size() - 1)];
  endfunction

  // Pick a tick time around the next advance point
  function automatic logic [TIME_W-1:0] tick_time();
    logic [TIME_W-1:0] span;
    case ($urandom_range(9))
      0, 1, 2: span = (wheel_period == 0) ? '0 : TIME_W'($urandom_range(wheel_period - 1, 0));
      3, 4:    span = TIME_W'(wheel_period);
      5, 6, 7: span = TIME_W'(wheel_period) + TIME_W'($urandom_range(5000, 1));
      8:       span = {$urandom, $urandom};
      default: span = -TIME_W'($urandom_range(5000, 1));
    endcase
    return last_advance + span;
  endfunction

  // Offer one word, wait for accept, then record its expected result
  task automatic send_word(kind_e k, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
    case ((words_sent / 50) % 4)
      0: begin feed_gap_pct = 0;  sink_stall_pct = 0;  end
      1: begin feed_gap_pct = 71; sink_stall_pct = 0;  end
      2: begin feed_gap_pct = 0;  sink_stall_pct = 71; end
      default: begin feed_gap_pct = 31; sink_stall_pct = 31; end
    endcase
    @(negedge clk_i);
    while ($urandom_range(99) < feed_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    session_id_i <= id;
    now_us_i     <= t;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    pending_outcomes.push_back(wheel_step(k, id, t));
    words_sent++;
  endtask

  task automatic random_word(int ins_pct, int upd_pct, int rem_pct, int dup_pct);
    int roll;
    logic [ID_W-1:0] id;
    logic [TIME_W-1:0] t;
    roll = $urandom_range(99);
    t = {$urandom, $urandom};
    if (roll < ins_pct) begin
      id = ($urandom_range(99) < dup_pct) ? known_id() : $urandom;
      send_word(KIND_INSERT, id, t);
    end else if (roll < ins_pct + upd_pct) begin
      send_word(KIND_UPDATE, known_id(), t);
    end else if (roll < ins_pct + upd_pct + rem_pct) begin
      send_word(KIND_REMOVE, known_id(), t);
    end else begin
      send_word(KIND_TICK, $urandom, tick_time());
    end
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic settle(int tail);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IX_W-1:0] ix, logic [CFG_D_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ix;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    if (ix == CFG_SLOT_TOP) begin
      wheel_top_reg = data[SLOT_W-1:0];
    end else begin
      wheel_period = data;
    end
  endtask

  task automatic program_wheel(logic [SLOT_W-1:0] top, logic [31:0] period);
    settle(16);
    write_reg(CFG_SLOT_TOP, CFG_D_W'(top));
    write_reg(CFG_TICK_PERIOD, period);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // Defaults after reset: duplicates, unknown ids, freshest slot, first advance
  task automatic test_reset_state();
    send_word(KIND_INSERT, '0, '0);
    send_word(KIND_INSERT, '0, '0);
    send_word(KIND_INSERT, '1, '1);
    send_word(KIND_UPDATE, '0, '1);
    send_word(KIND_UPDATE, 32'h1234_5678, '0);
    send_word(KIND_REMOVE, 32'h1234_5678, '0);
    send_word(KIND_TICK, '1, 64'd0);
    send_word(KIND_TICK, '0, 64'd999_999);
    send_word(KIND_TICK, 32'h5a5a_a5a5, 64'd1_000_000);
    send_word(KIND_UPDATE, '0, '0);
    send_word(KIND_UPDATE, '0, '0);
  endtask

  // One-slot wheel, zero period, top lowered under the current slot, expiry
  task automatic test_wheel_wrap();
    program_wheel('0, '0);
    send_word(KIND_TICK, '0, 64'd0);
    send_word(KIND_INSERT, 32'd7, '0);
    send_word(KIND_TICK, '0, 64'd5);
    send_word(KIND_UPDATE, 32'd7, '0);
    send_word(KIND_TICK, '0, 64'd5);
    send_word(KIND_REMOVE, 32'd7, '0);
    send_word(KIND_REMOVE, '0, '0);
    send_word(KIND_REMOVE, '1, '0);
  endtask

  // Widest wheel, longest period: one short of the period, then exactly it
  task automatic test_long_period();
    program_wheel(8'hFF, '1);
    send_word(KIND_TICK, '0, last_advance + 64'h0000_0000_FFFF_FFFE);
    send_word(KIND_TICK, '0, last_advance + 64'h0000_0000_FFFF_FFFF);
    send_word(KIND_TICK, '1, '1);
  endtask

  task automatic test_mixed_traffic();
    program_wheel(8'd3, 32'd100);
    repeat (120) random_word(35, 20, 10, 15);
  endtask

  // Fill the table, then hammer it with rejected inserts and refills
  task automatic test_table_full();
    program_wheel(8'hFF, 32'd1);
    while (live_ids.size() < SESSIONS) random_word(95, 2, 0, 3);
    repeat (30) random_word(60, 15, 5, 30);
  endtask

  // Hold the result side while words keep coming so the input backs up
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_word(KIND_TICK, $urandom, tick_time());
    send_word(KIND_INSERT, $urandom, '0);
    send_word(KIND_UPDATE, known_id(), '0);
    send_word(KIND_REMOVE, known_id(), '0);
  endtask

  task automatic test_narrow_wheel();
    program_wheel(8'd1, '1);
    repeat (80) random_word(20, 25, 15, 20);
  endtask

  task automatic test_remove_drain();
    program_wheel(8'd17, '0);
    repeat (80) random_word(10, 20, 40, 10);
  endtask

  // ------------------------------------------------------------ processes

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_INSERT;
    session_id_i = '0;
    now_us_i     = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_SLOT_TOP;
    cfg_data_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_wheel_wrap();
    test_long_period();
    test_mixed_traffic();
    test_table_full();
    test_backpressure();
    test_narrow_wheel();
    test_remove_drain();

    settle(SESSIONS + 16);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("[idle_session_timing_wheel] OK");
    end else begin
      $display("[idle_session_timing_wheel] ERROR");
    end
    $finish;
  end

  // Drive the result-side stall; a hold request freezes it for a long stretch
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic log_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: mismatch: %s", $time, what);
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    wheel_word_t want;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_outcomes.size() == 0) begin
        log_mismatch($sformatf("unexpected word: status %0d expire %0d slot %0d",
                               status_o, expire_valid_o, expire_slot_o));
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status) begin
          log_mismatch($sformatf("status expected %0d got %0d", want.status, status_o));
        end
        if (expire_valid_o !== want.expire) begin
          log_mismatch($sformatf("expire_valid expected %0d got %0d",
                                 want.expire, expire_valid_o));
        end
        if (expire_slot_o !== want.slot) begin
          log_mismatch($sformatf("expire_slot expected %0d got %0d",
                                 want.slot, expire_slot_o));
        end
      end
    end
  end

  // End the run when no channel has moved a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[idle_session_timing_wheel] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
